// ===== src/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion converter
package rmq_pkg;

   localparam int DATA_W = 16;            // element and component width
   localparam int FRAC_W = 14;            // fraction bits of every element
   localparam int THR_W  = 15;            // threshold register width
   localparam int SUM_W  = DATA_W + 2;    // sums of up to three elements plus one
   localparam int RAD_W  = DATA_W + 1;    // clamped radicand, always below 2^17
   localparam int SQ_W   = RAD_W + FRAC_W;        // radicand scaled by the fraction
   localparam int SQR_W  = SQ_W + 2;              // square root remainder width
   localparam int ROOT_W = (SQ_W + 1) / 2;        // root width
   localparam int DIV_W  = ROOT_W + 1;            // divisor 2r
   localparam int QB     = DATA_W + 1;            // quotient bits kept before clamping
   localparam int MAG_W  = DATA_W + 1;            // numerator magnitude
   localparam int REM_W  = DIV_W + QB;            // divider remainder width

   localparam logic [1:0] CASE_TRACE = 2'd0;
   localparam logic [1:0] CASE_X     = 2'd1;
   localparam logic [1:0] CASE_Y     = 2'd2;
   localparam logic [1:0] CASE_Z     = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } rmq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
      logic signed [DATA_W-1:0] quat_w;
      logic [1:0]               case_taken;
      logic                     degenerate;
   } rmq_rsp_type;

   // one square root stage
   typedef struct packed {
      logic                        v;
      logic [1:0]                  sel;
      logic [SQR_W-1:0]            rem;
      logic [ROOT_W-1:0]           root;
      logic [2:0][SUM_W-1:0]       num;
   } rmq_sq_type;

   // one divider stage, three lanes
   typedef struct packed {
      logic                        v;
      logic [1:0]                  sel;
      logic [ROOT_W-1:0]           root;
      logic [DIV_W-1:0]            dvs;
      logic [2:0]                  neg;
      logic [2:0]                  ovf;
      logic [2:0][REM_W-1:0]       rem;
      logic [2:0][QB-1:0]          quo;
   } rmq_dv_type;

endpackage

// ===== src/rotation_matrix_to_quaternion.sv =====
// rotation matrix to quaternion converter, pipelined root and dividers
// throughput: one matrix per cycle while req_stall is low; 1 setup stage, 16 root stages (one root bit each),
// 1 divider setup stage, 17 divider stages (one quotient bit each), output register
// a skid register behind the output word absorbs a stall; req_stall is registered
// synchronous active-high reset clears all valid bits, the pipeline stages and the threshold
module rotation_matrix_to_quaternion (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  rmq_pkg::rmq_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rmq_pkg::rmq_rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rmq_pkg::THR_W-1:0]    csr_data
);
   import rmq_pkg::*;

   localparam int SQ_STAGES = ROOT_W;
   localparam int DV_STAGES = QB;

   logic [THR_W-1:0] thr_ff;
   logic             skid_v_ff;
   logic             rsp_valid_ff;
   rmq_rsp_type      rsp_ff;
   rmq_rsp_type      skid_ff;
   rmq_rsp_type      pipe_word;
   logic             en;

   rmq_sq_type sq_ff [0:SQ_STAGES];
   rmq_sq_type sq_in [0:SQ_STAGES];
   rmq_dv_type dv_ff [0:DV_STAGES];
   rmq_dv_type dv_in [0:DV_STAGES];

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // setup: radicand, case and numerators
   logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [SUM_W-1:0] tr, r1, r2, r3, rad_s, thr_s, one_s;
   logic signed [SUM_W-1:0] dxa, dya, dza, s01, s02, s12;
   logic [1:0]              sel;

   always_comb begin
      e00 = SUM_W'(req_data.m00);
      e01 = SUM_W'(req_data.m01);
      e02 = SUM_W'(req_data.m02);
      e10 = SUM_W'(req_data.m10);
      e11 = SUM_W'(req_data.m11);
      e12 = SUM_W'(req_data.m12);
      e20 = SUM_W'(req_data.m20);
      e21 = SUM_W'(req_data.m21);
      e22 = SUM_W'(req_data.m22);
      one_s = SUM_W'(1) <<< FRAC_W;
      thr_s = signed'({{(SUM_W-THR_W){1'b0}}, thr_ff});
      tr  = one_s + e00 + e11 + e22;
      r1  = one_s + e00 - e11 - e22;
      r2  = one_s + e11 - e00 - e22;
      r3  = one_s + e22 - e00 - e11;
      dxa = e12 - e21;
      dya = e20 - e02;
      dza = e01 - e10;
      s01 = e10 + e01;
      s02 = e20 + e02;
      s12 = e21 + e12;

      sq_in[0] = '0;
      sq_in[0].v = req_valid;
      if (tr > thr_s) begin
         sel = CASE_TRACE;
         rad_s = tr;
         sq_in[0].num = {dza, dya, dxa};
      end else if (e00 > e11 && e00 > e22) begin
         sel = CASE_X;
         rad_s = r1;
         sq_in[0].num = {dxa, s02, s01};
      end else if (e11 > e22) begin
         sel = CASE_Y;
         rad_s = r2;
         sq_in[0].num = {dya, s12, s01};
      end else begin
         sel = CASE_Z;
         rad_s = r3;
         sq_in[0].num = {dza, s12, s02};
      end
      sq_in[0].sel = sel;
      // negative radicand clamps to zero
      if (rad_s > 0) begin
         sq_in[0].rem = SQR_W'({rad_s[RAD_W-1:0], {FRAC_W{1'b0}}});
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
      localparam int B = SQ_STAGES - 1 - k;
      logic [SQR_W-1:0] trial;
      always_comb begin
         trial = (SQR_W'(sq_ff[k].root) << (B + 1)) + (SQR_W'(1) << (2 * B));
         sq_in[k+1] = sq_ff[k];
         if (sq_ff[k].rem >= trial) begin
            sq_in[k+1].rem  = sq_ff[k].rem - trial;
            sq_in[k+1].root = sq_ff[k].root | (ROOT_W'(1) << B);
         end
      end
   end

   for (genvar k = 0; k <= SQ_STAGES; k++) begin : g_sq_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k] <= '0;
         end else if (en) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   // divider setup: magnitudes, signs and overflow of the quotient
   always_comb begin
      logic signed [SUM_W-1:0] n;
      logic [SUM_W-1:0]        a;
      logic [REM_W-1:0]        lim;
      dv_in[0]      = '0;
      dv_in[0].v    = sq_ff[SQ_STAGES].v;
      dv_in[0].sel  = sq_ff[SQ_STAGES].sel;
      dv_in[0].root = sq_ff[SQ_STAGES].root;
      dv_in[0].dvs  = {sq_ff[SQ_STAGES].root, 1'b0};
      lim = REM_W'({sq_ff[SQ_STAGES].root, 1'b0}) << QB;
      for (int j = 0; j < 3; j++) begin
         n = signed'(sq_ff[SQ_STAGES].num[j]);
         a = (n < 0) ? SUM_W'(-n) : SUM_W'(n);
         dv_in[0].neg[j] = n < 0;
         dv_in[0].rem[j] = REM_W'({a[MAG_W-1:0], {FRAC_W{1'b0}}});
         dv_in[0].ovf[j] = dv_in[0].rem[j] >= lim;
      end
   end

   // three restoring dividers, one quotient bit per stage
   for (genvar k = 0; k < DV_STAGES; k++) begin : g_dv
      localparam int B = DV_STAGES - 1 - k;
      logic [REM_W-1:0] dsh;
      always_comb begin
         dsh = REM_W'(dv_ff[k].dvs) << B;
         dv_in[k+1] = dv_ff[k];
         for (int j = 0; j < 3; j++) begin
            if (dv_ff[k].rem[j] >= dsh) begin
               dv_in[k+1].rem[j] = dv_ff[k].rem[j] - dsh;
               dv_in[k+1].quo[j] = dv_ff[k].quo[j] | (QB'(1) << B);
            end
         end
      end
   end

   for (genvar k = 0; k <= DV_STAGES; k++) begin : g_dv_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= '0;
         end else if (en) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // clamp, sign and place the components
   localparam logic [QB-1:0] QLIM = QB'(1) << (DATA_W - 1);
   localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};

   always_comb begin
      logic [2:0][DATA_W-1:0] c;
      logic [QB-1:0]          qm;
      logic [DATA_W-1:0]      half;
      rmq_dv_type             f;
      f = dv_ff[DV_STAGES];
      for (int j = 0; j < 3; j++) begin
         qm = (f.ovf[j] || f.quo[j] > QLIM) ? QLIM : f.quo[j];
         if (f.neg[j]) begin
            c[j] = DATA_W'(-qm);
         end else begin
            c[j] = (qm > QB'(SMAX)) ? SMAX : qm[DATA_W-1:0];
         end
      end
      half = DATA_W'(f.root >> 1);
      pipe_word = '0;
      pipe_word.case_taken = f.sel;
      pipe_word.degenerate = (f.root == '0);
      if (f.root != '0) begin
         case (f.sel)
            CASE_TRACE: begin
               pipe_word.quat_x = c[0];
               pipe_word.quat_y = c[1];
               pipe_word.quat_z = c[2];
               pipe_word.quat_w = half;
            end
            CASE_X: begin
               pipe_word.quat_x = half;
               pipe_word.quat_y = c[0];
               pipe_word.quat_z = c[1];
               pipe_word.quat_w = c[2];
            end
            CASE_Y: begin
               pipe_word.quat_x = c[0];
               pipe_word.quat_y = half;
               pipe_word.quat_z = c[1];
               pipe_word.quat_w = c[2];
            end
            default: begin
               pipe_word.quat_x = c[0];
               pipe_word.quat_y = c[1];
               pipe_word.quat_z = half;
               pipe_word.quat_w = c[2];
            end
         endcase
      end
   end

   // output word register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (skid_v_ff) begin
         if (!rsp_stall) begin
            skid_v_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= dv_ff[DV_STAGES].v;
      end else if (dv_ff[DV_STAGES].v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (!rsp_stall) begin
            rsp_ff <= skid_ff;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= pipe_word;
      end else begin
         skid_ff <= pipe_word;
      end
   end

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff) else $error("skid full while output empty");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.degenerate |-> rsp_ff.quat_x == '0 && rsp_ff.quat_y == '0
      && rsp_ff.quat_z == '0 && rsp_ff.quat_w == '0) else $error("degenerate word not zero");
   a_trace_w_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.case_taken == CASE_TRACE |-> !rsp_ff.quat_w[DATA_W-1])
      else $error("trace case w negative");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !skid_v_ff) else $error("valid after reset");
`endif

endmodule

// ===== verif/tb_rotation_matrix_to_quaternion.sv =====
// self-checking testbench for the rotation matrix to quaternion converter
module tb_rotation_matrix_to_quaternion;
   timeunit 1ns;
   timeprecision 1ps;

   import rmq_pkg::*;

   localparam int LATENCY   = 36;
   localparam int MAX_CYCLE = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   rmq_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rmq_rsp_type          rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [THR_W-1:0]     csr_data = '0;

   rmq_req_type          pending_words[$];
   rmq_rsp_type          expected_quats[$];
   logic [THR_W-1:0]     threshold_q = '0;
   int                   error_count = 0;
   int                   cycle_count = 0;
   bit                   quiet_phase = 1'b0;
   bit                   hold_req = 1'b0;
   int                   req_gap = 0;
   int                   rsp_gap = 0;

   rotation_matrix_to_quaternion uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // truncated integer square root
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // (num << frac) / 2r toward zero, saturated
   function automatic logic [DATA_W-1:0] scaled_quot(longint num, longint unsigned r);
      longint unsigned mag;
      longint unsigned q;
      longint v;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag << FRAC_W) / (r * 2);
      v = (q > 32768) ? 32768 : longint'(q);
      return DATA_W'(clamp16((num < 0) ? -v : v));
   endfunction

   function automatic longint unsigned root_of(longint rad);
      if (rad <= 0) return 0;
      return int_sqrt(longint'(rad) << FRAC_W);
   endfunction

   function automatic rmq_rsp_type predict_quat(rmq_req_type m, logic [THR_W-1:0] thr);
      rmq_rsp_type res;
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one, t;
      longint unsigned r;
      logic [DATA_W-1:0] half;
      a00 = m.m00; a01 = m.m01; a02 = m.m02;
      a10 = m.m10; a11 = m.m11; a12 = m.m12;
      a20 = m.m20; a21 = m.m21; a22 = m.m22;
      one = 64'd1 << FRAC_W;
      t = one + a00 + a11 + a22;
      res = '0;
      if (t > longint'(thr)) begin
         res.case_taken = CASE_TRACE;
         r = root_of(t);
      end else if (a00 > a11 && a00 > a22) begin
         res.case_taken = CASE_X;
         r = root_of(one + a00 - a11 - a22);
      end else if (a11 > a22) begin
         res.case_taken = CASE_Y;
         r = root_of(one + a11 - a00 - a22);
      end else begin
         res.case_taken = CASE_Z;
         r = root_of(one + a22 - a00 - a11);
      end
      res.degenerate = (r == 0);
      if (r != 0) begin
         half = DATA_W'(clamp16(longint'(r >> 1)));
         case (res.case_taken)
            CASE_TRACE: begin
               res.quat_x = scaled_quot(a12 - a21, r);
               res.quat_y = scaled_quot(a20 - a02, r);
               res.quat_z = scaled_quot(a01 - a10, r);
               res.quat_w = half;
            end
            CASE_X: begin
               res.quat_x = half;
               res.quat_y = scaled_quot(a10 + a01, r);
               res.quat_z = scaled_quot(a20 + a02, r);
               res.quat_w = scaled_quot(a12 - a21, r);
            end
            CASE_Y: begin
               res.quat_x = scaled_quot(a10 + a01, r);
               res.quat_y = half;
               res.quat_z = scaled_quot(a21 + a12, r);
               res.quat_w = scaled_quot(a20 - a02, r);
            end
            default: begin
               res.quat_x = scaled_quot(a20 + a02, r);
               res.quat_y = scaled_quot(a21 + a12, r);
               res.quat_z = half;
               res.quat_w = scaled_quot(a01 - a10, r);
            end
         endcase
      end
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_quats.push_back(predict_quat(req_data, threshold_q));
         end
         if (!req_valid || !req_stall) begin
            if (hold_req) begin
               req_valid <= 1'b0;
            end else if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
               req_gap <= $urandom_range(1, 9) - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      rmq_rsp_type exp_w;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_quats.size() == 0) begin
               $error("unexpected word %h", rsp_data);
               error_count = error_count + 1;
            end else begin
               exp_w = expected_quats.pop_front();
               if (rsp_data.quat_x !== exp_w.quat_x) begin
                  $error("quat_x expected %0d actual %0d", exp_w.quat_x, rsp_data.quat_x);
                  error_count = error_count + 1;
               end
               if (rsp_data.quat_y !== exp_w.quat_y) begin
                  $error("quat_y expected %0d actual %0d", exp_w.quat_y, rsp_data.quat_y);
                  error_count = error_count + 1;
               end
               if (rsp_data.quat_z !== exp_w.quat_z) begin
                  $error("quat_z expected %0d actual %0d", exp_w.quat_z, rsp_data.quat_z);
                  error_count = error_count + 1;
               end
               if (rsp_data.quat_w !== exp_w.quat_w) begin
                  $error("quat_w expected %0d actual %0d", exp_w.quat_w, rsp_data.quat_w);
                  error_count = error_count + 1;
               end
               if (rsp_data.case_taken !== exp_w.case_taken) begin
                  $error("case_taken expected %0d actual %0d",
                         exp_w.case_taken, rsp_data.case_taken);
                  error_count = error_count + 1;
               end
               if (rsp_data.degenerate !== exp_w.degenerate) begin
                  $error("degenerate expected %0d actual %0d",
                         exp_w.degenerate, rsp_data.degenerate);
                  error_count = error_count + 1;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
            rsp_gap <= $urandom_range(1, 9) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
      if (cycle_count > MAX_CYCLE) begin
         $display("tb_rotation_matrix_to_quaternion failed");
         $finish;
      end
   end

   function automatic rmq_req_type uniform_matrix(logic signed [DATA_W-1:0] v);
      return {9{v}};
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return DATA_W'($urandom_range(0, 32768)) - 16'sd16384;
         default: return DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // near-rotation: axis permutation with sign flips plus a small jitter, or else random elements
   function automatic rmq_req_type rand_matrix();
      rmq_req_type m;
      logic signed [DATA_W-1:0] e[9];
      int unsigned perm;
      int p[3];
      if ($urandom_range(0, 3) == 0) begin
         foreach (e[i]) e[i] = rand_elem();
      end else begin
         perm = $urandom_range(0, 5);
         p[0] = perm % 3;
         p[1] = (p[0] + 1 + perm / 3) % 3;
         p[2] = 3 - p[0] - p[1];
         foreach (e[i]) e[i] = DATA_W'($urandom_range(0, 8000)) - 16'sd4000;
         for (int i = 0; i < 3; i++) begin
            e[i * 3 + p[i]] = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                              + DATA_W'($urandom_range(0, 6000)) - 16'sd3000;
         end
      end
      m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      return m;
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_quats.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      threshold_q = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [THR_W-1:0] settings[5];
      rmq_req_type m;
      settings = '{15'd0, 15'd16384, 15'd8192, 15'd1, 15'd32767};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed words at reset threshold
      pending_words.push_back('0);
      pending_words.push_back(uniform_matrix(16'sh7fff));
      pending_words.push_back(uniform_matrix(16'sh8000));
      pending_words.push_back(uniform_matrix(-16'sd1));
      m = '0; m.m00 = 16'sd16384; m.m11 = 16'sd16384; m.m22 = 16'sd16384;
      pending_words.push_back(m);
      m = '0; m.m00 = 16'sd16384; m.m11 = -16'sd16384; m.m22 = -16'sd16384;
      pending_words.push_back(m);
      m = '0; m.m00 = -16'sd16384; m.m11 = 16'sd16384; m.m22 = -16'sd16384;
      pending_words.push_back(m);
      m = '0; m.m00 = -16'sd16384; m.m11 = -16'sd16384; m.m22 = 16'sd16384;
      pending_words.push_back(m);
      // diagonal ties, negative trace
      m = '0; m.m00 = -16'sd8192; m.m11 = -16'sd8192; m.m22 = -16'sd8192;
      pending_words.push_back(m);
      m = '0; m.m00 = -16'sd16384; m.m11 = -16'sd16384; m.m22 = -16'sd20000;
      pending_words.push_back(m);
      m = uniform_matrix(16'sh7fff); m.m00 = -16'sd32768; m.m11 = -16'sd32768;
      m.m22 = -16'sd32768;
      pending_words.push_back(m);
      m = uniform_matrix(16'sh8000); m.m00 = -16'sd16384; m.m11 = -16'sd16384;
      m.m22 = -16'sd16383;
      pending_words.push_back(m);
      for (int i = 0; i < 8; i++) pending_words.push_back(rand_matrix());
      wait_drained();
      for (int s = 0; s < 5; s++) begin
         write_threshold(settings[s]);
         for (int i = 0; i < 240; i++) pending_words.push_back(rand_matrix());
         // sender holds off once until the pipe is empty
         if (s == 2) begin
            while (pending_words.size() > 120) @(posedge clock);
            hold_req = 1'b1;
            while (expected_quats.size() > 0 || req_valid) @(posedge clock);
            hold_req = 1'b0;
         end
         wait_drained();
      end
      write_threshold(THR_W'($urandom_range(0, 16384)));
      quiet_phase = 1'b1;
      for (int i = 0; i < 230; i++) pending_words.push_back(rand_matrix());
      wait_drained();
      if (error_count == 0) begin
         $display("tb_rotation_matrix_to_quaternion passed");
      end else begin
         $display("tb_rotation_matrix_to_quaternion failed");
      end
      $finish;
   end

endmodule
